// ===== rtl/swr_pkg.sv =====
`default_nettype none
package swr_pkg;

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W = $clog2(QUEUE_DEPTH);

  localparam logic [7:0] FLAG_ACK         = 8'h03;
  localparam logic [7:0] FLAG_LAST        = 8'h18;
  localparam logic [7:0] FLAG_OPEN        = 8'h01;
  localparam logic [7:0] FLAG_OPEN_REPLY  = 8'h02;
  localparam logic [7:0] FLAG_CONFIRM     = 8'h04;
  localparam logic [7:0] FLAG_CLOSE       = 8'h80;
  localparam logic [7:0] FLAG_CLOSE_REPLY = 8'h40;
  localparam logic [7:0] SUM_GOOD         = 8'hFF;

  localparam logic [1:0] KIND_PAYLOAD = 2'd0;
  localparam logic [1:0] KIND_REPLY   = 2'd1;
  localparam logic [1:0] KIND_VERDICT = 2'd2;

  typedef enum logic [2:0] {
    PH_AWAIT_OPEN    = 3'd0,
    PH_AWAIT_CONFIRM = 3'd1,
    PH_DATA          = 3'd2,
    PH_AWAIT_CLOSE   = 3'd3,
    PH_CLOSED        = 3'd4
  } phase_t;

  typedef enum logic [1:0] {
    REPLY_NONE = 2'd0,
    REPLY_CTRL = 2'd1,
    REPLY_ACK  = 2'd2
  } reply_t;

  // Everything one input byte causes, in compressed form.
  typedef struct packed {
    logic       has_pay;
    logic [7:0] pay;
    logic       is_end;
    reply_t     reply;
    logic [7:0] rbyte;    // reply flag, or ack number for data acks
    logic       acc;
    logic       mend;
    phase_t     phase;
  } step_t;

  // 8-bit end-around-carry add
  function automatic logic [7:0] fold_add(input logic [7:0] s, input logic [7:0] b);
    logic [8:0] t;
    t = {1'b0, s} + {1'b0, b};
    return t[7:0] + {7'd0, t[8]};
  endfunction

endpackage
`default_nettype wire

// ===== rtl/swr_front.sv =====
`default_nettype none
module swr_front #(
  parameter int unsigned MAX_PAYLOAD = 253
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic [7:0]     messages_per_session,
  input  wire logic           in_valid,
  input  wire logic [7:0]     rx_byte,
  input  wire logic           datagram_end,
  input  wire logic           accept,
  output swr_pkg::step_t      step,
  output logic                step_push
);

  localparam logic [9:0] OVL_LIMIT = 10'(MAX_PAYLOAD + 3);
  localparam logic [9:0] PAY_STOP  = 10'(MAX_PAYLOAD + 3);
  localparam logic [9:0] MAX_W     = 10'(MAX_PAYLOAD);

  swr_pkg::phase_t phase, phase_next;
  logic [7:0] expected_sequence, exp_next;
  logic [7:0] running_sum;
  logic [8:0] byte_position;
  logic [7:0] flag_seen;
  logic [7:0] sequence_seen;
  logic [7:0] payload_length;
  logic [7:0] messages_done, md_next;
  logic       overlong;

  logic [9:0] pos;
  logic       ovl;
  logic [7:0] sum_new, flag_eff, seq_eff, len_eff, e1;
  logic       good, two, take, acc, mend;
  swr_pkg::reply_t reply;
  logic [7:0] rbyte;

  always_comb begin
    pos      = {1'b0, byte_position};
    ovl      = overlong || (pos > OVL_LIMIT);
    sum_new  = swr_pkg::fold_add(running_sum, rx_byte);
    flag_eff = (pos == 10'd1) ? rx_byte : flag_seen;
    seq_eff  = (pos == 10'd2) ? rx_byte : sequence_seen;
    if (pos == 10'd3) begin
      len_eff = ({2'b00, rx_byte} > MAX_W) ? MAX_W[7:0] : rx_byte;
    end else begin
      len_eff = payload_length;
    end

    if (flag_eff == swr_pkg::FLAG_LAST) begin
      take = (pos >= 10'd4) && (pos < 10'd4 + {2'b00, len_eff});
    end else begin
      take = (pos >= 10'd3) && (pos < PAY_STOP);
    end
    take = take && (phase == swr_pkg::PH_DATA) && !ovl;

    good       = (sum_new == swr_pkg::SUM_GOOD);
    two        = !ovl && (pos == 10'd1);
    phase_next = phase;
    exp_next   = expected_sequence;
    md_next    = messages_done;
    acc        = 1'b0;
    mend       = 1'b0;
    reply      = swr_pkg::REPLY_NONE;
    rbyte      = 8'h00;
    e1         = 8'h00;

    case (phase)
      swr_pkg::PH_AWAIT_OPEN: begin
        if (good && two && flag_eff == swr_pkg::FLAG_OPEN) begin
          reply      = swr_pkg::REPLY_CTRL;
          rbyte      = swr_pkg::FLAG_OPEN_REPLY;
          phase_next = swr_pkg::PH_AWAIT_CONFIRM;
          acc        = 1'b1;
        end
      end
      swr_pkg::PH_AWAIT_CONFIRM: begin
        if (good && two && flag_eff == swr_pkg::FLAG_OPEN) begin
          reply = swr_pkg::REPLY_CTRL;
          rbyte = swr_pkg::FLAG_OPEN_REPLY;
          acc   = 1'b1;
        end else if (good && two && flag_eff == swr_pkg::FLAG_CONFIRM) begin
          phase_next = swr_pkg::PH_DATA;
          acc        = 1'b1;
        end else begin
          phase_next = swr_pkg::PH_AWAIT_OPEN;
        end
      end
      swr_pkg::PH_DATA: begin
        if (!ovl) begin
          if (good && seq_eff == expected_sequence) begin
            exp_next = expected_sequence + 8'd1;
            acc      = 1'b1;
          end
          e1    = exp_next - 8'd1;
          reply = swr_pkg::REPLY_ACK;
          rbyte = e1;
          if (acc && flag_eff == swr_pkg::FLAG_LAST) begin
            if (messages_done != 8'hFF) begin
              md_next = messages_done + 8'd1;
            end
            mend = 1'b1;
            if (md_next >= messages_per_session) begin
              phase_next = swr_pkg::PH_AWAIT_CLOSE;
            end
          end
        end
      end
      swr_pkg::PH_AWAIT_CLOSE: begin
        if (good && two && flag_eff == swr_pkg::FLAG_CLOSE) begin
          reply      = swr_pkg::REPLY_CTRL;
          rbyte      = swr_pkg::FLAG_CLOSE_REPLY;
          phase_next = swr_pkg::PH_CLOSED;
          acc        = 1'b1;
        end
      end
      default: begin
      end
    endcase

    if (!datagram_end) begin
      phase_next = phase;
      exp_next   = expected_sequence;
      md_next    = messages_done;
      reply      = swr_pkg::REPLY_NONE;
      acc        = 1'b0;
      mend       = 1'b0;
    end

    step.has_pay = take;
    step.pay     = rx_byte;
    step.is_end  = datagram_end;
    step.reply   = reply;
    step.rbyte   = rbyte;
    step.acc     = acc;
    step.mend    = mend;
    step.phase   = phase_next;
    step_push    = in_valid && accept && (take || datagram_end);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= swr_pkg::PH_AWAIT_OPEN;
      expected_sequence <= 8'h00;
      running_sum       <= 8'h00;
      byte_position     <= 9'd0;
      flag_seen         <= 8'h00;
      sequence_seen     <= 8'h00;
      payload_length    <= 8'h00;
      messages_done     <= 8'h00;
      overlong          <= 1'b0;
    end else if (in_valid && accept) begin
      phase             <= phase_next;
      expected_sequence <= exp_next;
      messages_done     <= md_next;
      if (datagram_end) begin
        running_sum    <= 8'h00;
        byte_position  <= 9'd0;
        flag_seen      <= 8'h00;
        sequence_seen  <= 8'h00;
        payload_length <= 8'h00;
        overlong       <= 1'b0;
      end else begin
        running_sum    <= sum_new;
        flag_seen      <= flag_eff;
        sequence_seen  <= seq_eff;
        payload_length <= len_eff;
        overlong       <= ovl;
        if (byte_position != 9'h1FF) begin
          byte_position <= byte_position + 9'd1;
        end
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/swr_queue.sv =====
`default_nettype none
module swr_queue (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  wire swr_pkg::step_t push_data,
  output logic                not_full,
  input  wire logic           pop,
  output logic                head_valid,
  output swr_pkg::step_t      head
);

  localparam int unsigned CNT_W = $clog2(swr_pkg::QUEUE_DEPTH + 1);

  swr_pkg::step_t                 mem [swr_pkg::QUEUE_DEPTH];
  logic [swr_pkg::QPTR_W-1:0]     wr_ptr, rd_ptr;
  logic [CNT_W-1:0]               count;

  assign not_full   = (count < CNT_W'(swr_pkg::QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head       = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/swr_back.sv =====
`default_nettype none
module swr_back (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           head_valid,
  input  wire swr_pkg::step_t head,
  output logic                pop,
  output logic                m_tvalid,
  input  wire logic           m_tready,
  output logic [15:0]         m_tdata,   // out_byte[7:0], session_phase[10:8]
  output logic                m_tlast,   // reply_end
  output logic [4:0]          m_tuser    // result_kind[1:0], packet_accepted, message_end,
                                         // last_result
);

  logic [2:0] idx;
  logic [2:0] rc, n, r;
  logic [1:0] kind;
  logic [7:0] obyte;
  logic       rend, acc, mend, last, load;

  always_comb begin
    case (head.reply)
      swr_pkg::REPLY_CTRL: rc = 3'd2;
      swr_pkg::REPLY_ACK:  rc = 3'd3;
      default:             rc = 3'd0;
    endcase
    n     = {2'b00, head.has_pay} + rc + {2'b00, head.is_end};
    r     = idx - {2'b00, head.has_pay};
    kind  = swr_pkg::KIND_VERDICT;
    obyte = 8'h00;
    rend  = 1'b0;
    acc   = 1'b0;
    mend  = 1'b0;
    if (head.has_pay && idx == 3'd0) begin
      kind  = swr_pkg::KIND_PAYLOAD;
      obyte = head.pay;
    end else if (r < rc) begin
      kind = swr_pkg::KIND_REPLY;
      if (head.reply == swr_pkg::REPLY_CTRL) begin
        obyte = (r == 3'd0) ? ~head.rbyte : head.rbyte;
        rend  = (r == 3'd1);
      end else begin
        case (r)
          3'd0:    obyte = ~swr_pkg::fold_add(swr_pkg::FLAG_ACK, head.rbyte);
          3'd1:    obyte = swr_pkg::FLAG_ACK;
          default: begin
            obyte = head.rbyte;
            rend  = 1'b1;
          end
        endcase
      end
    end else begin
      acc  = head.acc;
      mend = head.mend;
    end
    last = (idx == n - 3'd1);
    load = head_valid && (!m_tvalid || m_tready);
    pop  = load && last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx      <= 3'd0;
      m_tvalid <= 1'b0;
    end else begin
      if (!m_tvalid || m_tready) begin
        m_tvalid <= head_valid;
      end
      if (load) begin
        idx <= last ? 3'd0 : idx + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      m_tdata <= {5'd0, head.phase, obyte};
      m_tlast <= rend;
      m_tuser <= {last, mend, acc, kind};
    end
  end

endmodule
`default_nettype wire

// ===== rtl/stop_and_wait_receiver.sv =====
`default_nettype none
// Stop-and-wait session receiver. Datagram bytes enter on the s_ stream one
// transfer per cycle (s_tlast on the final byte); the front end checks the
// folded sum, tracks the handshake/data/close phases and records what each
// payload byte or datagram end causes in a four-entry step queue. The back
// end expands each record into result transfers on the m_ stream, one per
// cycle while m_tready allows: a tentative payload byte, reply bytes (2 for
// control replies, 3 for ACKs), then one verdict at each datagram end. Input
// is taken every cycle while the queue has room; a body byte yields at most
// one result and a datagram end up to five; the output port sets sustained throughput.
// messages_per_session sits at byte addresses 0-3 of the APB port (reset 2).
module stop_and_wait_receiver #(
  parameter int unsigned MAX_PAYLOAD = 253
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // rx_byte[7:0]
  input  wire logic        s_tlast,   // datagram_end
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [15:0]      m_tdata,   // out_byte[7:0], session_phase[10:8]
  output logic             m_tlast,   // reply_end
  output logic [4:0]       m_tuser,   // result_kind[1:0], packet_accepted, message_end,
                                      // last_result
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  logic [7:0]     messages_per_session;
  swr_pkg::step_t step, head;
  logic           step_push, not_full, pop, head_valid;

  assign pready   = 1'b1;
  assign prdata   = (paddr[2] == 1'b0) ? {24'd0, messages_per_session} : 32'd0;
  assign s_tready = not_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      messages_per_session <= 8'd2;
    end else if (psel && penable && pwrite && pready && paddr[2] == 1'b0) begin
      messages_per_session <= pwdata[7:0];
    end
  end

  swr_front #(
    .MAX_PAYLOAD(MAX_PAYLOAD)
  ) u_front (
    .clk                 (clk),
    .rst                 (rst),
    .messages_per_session(messages_per_session),
    .in_valid            (s_tvalid),
    .rx_byte             (s_tdata),
    .datagram_end        (s_tlast),
    .accept              (not_full),
    .step                (step),
    .step_push           (step_push)
  );

  swr_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (step_push),
    .push_data (step),
    .not_full  (not_full),
    .pop       (pop),
    .head_valid(head_valid),
    .head      (head)
  );

  swr_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head_valid(head_valid),
    .head      (head),
    .pop       (pop),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .m_tuser   (m_tuser)
  );

endmodule
`default_nettype wire
